// ===== design/ffa_pkg.sv =====
// Shared constants for the first-fit arena allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
    localparam int DATA_W = 24;
    localparam logic [DATA_W-1:0] ARENA_RESET = 24'd10000000;
    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE = 1'b1;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [0:0] REG_ARENA = 1'b0;
endpackage
`default_nettype wire

// ===== design/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/first_fit_arena_allocator_core.sv =====
// Top level of the first-fit arena allocator.
// Each request walks the chain one block at a time, then writes back any change; the chain
// walk reads one table entry per cycle from the block table memory.
// A split also waits for the spare-slot scan, which reads one slot per cycle from slot 1 of
// the slot-use memory and runs alongside the walk. A free of offset 0 is answered from idle
// without a walk. After reset or an arena_bytes write, an init pass clears the slot-use
// memory except slot 0, which it marks used, and rewrites table slot 0 before requests
// are taken.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_arena_allocator_core #(
    parameter int MAX_BLOCKS = 256,
    parameter int HEADER_BYTES = 16,
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // request_bytes[23:0], payload_offset[47:24]
    input  wire logic        i_s_tuser,  // op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,  // granted_offset
    output logic      [1:0]  o_m_tuser,  // status
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready
);
    import ffa_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = AW + 1;
    localparam int EW = 2 * DATA_W + 1 + LW;
    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_BLOCKS);
    localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);
    localparam logic [DATA_W-1:0] SPLIT_MIN = DATA_W'(HEADER_BYTES + MIN_BLOCK_BYTES);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_WALK, S_SPARE, S_SPLIT2, S_MERGE
    } t_state;

    t_state r_state;
    logic [DATA_W-1:0] r_arena;
    logic r_op;
    logic [DATA_W-1:0] r_want, r_off;
    logic [AW-1:0] r_cur, r_nx, r_spare;
    logic [DATA_W-1:0] r_start, r_size;
    logic [LW-1:0] r_link;
    logic [LW-1:0] r_scan;
    logic r_spare_ok;
    logic [LW-1:0] r_clr;
    logic [AW-1:0] r_chk;
    logic r_chk_vld;

    logic we;
    logic [AW-1:0] waddr, rd_addr;
    logic [EW-1:0] wdata, rdata;
    logic use_we, use_wdata, use_rdata;
    logic [AW-1:0] use_waddr;
    logic [DATA_W-1:0] d_start, d_size;
    logic d_free;
    logic [LW-1:0] d_link;
    logic alloc_hit, split_ok, free_hit, at_end, scan_done, in_acc, cfg_wr;
    logic [DATA_W-1:0] init_size, sum_sat, grant;
    logic [DATA_W+1:0] sum;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rdata)
    );

    ffa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_use (
        .i_clk  (i_clk),
        .i_we   (use_we),
        .i_waddr(use_waddr),
        .i_wdata(use_wdata),
        .i_raddr(r_scan[AW-1:0]),
        .o_rdata(use_rdata)
    );

    assign {d_start, d_size, d_free, d_link} = rdata;
    assign o_s_tready = (r_state == S_IDLE) && !o_m_tvalid;
    assign in_acc = i_s_tvalid && o_s_tready;
    assign cfg_wr = i_psel && i_penable && i_pwrite && o_pready && (i_paddr[2] == REG_ARENA);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_ARENA) ? {8'd0, r_arena} : 32'd0;

    assign alloc_hit = (r_op == OP_ALLOC) && d_free && (d_size >= r_want);
    assign split_ok = (d_size - r_want) >= SPLIT_MIN;
    assign free_hit = (r_op == OP_FREE) && ((d_start + HDR) == r_off);
    assign at_end = (d_link == LINK_NONE);
    assign scan_done = r_spare_ok || ((r_scan == LW'(MAX_BLOCKS)) && !r_chk_vld);
    assign init_size = (r_arena >= HDR) ? r_arena - HDR : '0;
    assign sum = {2'd0, r_size} + {2'd0, d_size} + {2'd0, HDR};
    assign sum_sat = (sum[DATA_W+1:DATA_W] != 2'd0) ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    assign grant = r_start + HDR;

    always_comb begin
        rd_addr = d_link[AW-1:0];
        we = 1'b0;
        waddr = r_cur;
        wdata = {r_start, r_size, 1'b0, r_link};
        case (r_state)
            S_INIT: begin
                we = 1'b1;
                waddr = '0;
                wdata = {{DATA_W{1'b0}}, init_size, 1'b1, LINK_NONE};
            end
            S_IDLE: begin
                rd_addr = '0;
            end
            S_WALK: begin
                if (alloc_hit && !split_ok) begin
                    we = 1'b1;
                    wdata = {d_start, d_size, 1'b0, d_link};
                end else if (!alloc_hit && free_hit && at_end) begin
                    we = 1'b1;
                    wdata = {d_start, d_size, 1'b1, d_link};
                end
            end
            S_SPARE: begin
                we = scan_done;
                if (r_spare_ok) begin
                    wdata = {r_start, r_want, 1'b0, {1'b0, r_spare}};
                end
            end
            S_SPLIT2: begin
                we = 1'b1;
                waddr = r_spare;
                wdata = {r_start + HDR + r_want, r_size - HDR - r_want, 1'b1, r_link};
            end
            S_MERGE: begin
                we = 1'b1;
                if (d_free) begin
                    wdata = {r_start, sum_sat, 1'b1, d_link};
                end else begin
                    wdata = {r_start, r_size, 1'b1, r_link};
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        use_we = 1'b0;
        use_waddr = r_clr[AW-1:0];
        use_wdata = (r_clr == '0);
        case (r_state)
            S_INIT: begin
                use_we = 1'b1;
            end
            S_SPARE: begin
                if (scan_done && r_spare_ok) begin
                    use_we = 1'b1;
                    use_waddr = r_spare;
                    use_wdata = 1'b1;
                end
            end
            S_MERGE: begin
                if (d_free) begin
                    use_we = 1'b1;
                    use_waddr = r_nx;
                    use_wdata = 1'b0;
                end
            end
            default: begin
                use_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_arena <= ARENA_RESET;
            r_clr <= '0;
            o_m_tvalid <= 1'b0;
            r_spare_ok <= 1'b0;
            r_chk_vld <= 1'b0;
            r_scan <= LW'(1);
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            if (r_state != S_IDLE && r_state != S_INIT && !scan_done) begin
                if (r_chk_vld && !use_rdata) begin
                    r_spare_ok <= 1'b1;
                    r_spare <= r_chk;
                end else begin
                    r_chk <= r_scan[AW-1:0];
                    r_chk_vld <= (r_scan != LW'(MAX_BLOCKS));
                    if (r_scan != LW'(MAX_BLOCKS)) begin
                        r_scan <= r_scan + LW'(1);
                    end
                end
            end
            if (cfg_wr) begin
                r_arena <= i_pwdata[DATA_W-1:0];
                r_clr <= '0;
                r_state <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_clr <= r_clr + LW'(1);
                        if (r_clr == LW'(MAX_BLOCKS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (in_acc) begin
                            r_op <= i_s_tuser;
                            r_want <= i_s_tdata[23:0];
                            r_off <= i_s_tdata[47:24];
                            r_cur <= '0;
                            r_scan <= LW'(1);
                            r_spare_ok <= 1'b0;
                            r_chk_vld <= 1'b0;
                            if (i_s_tuser == OP_FREE && i_s_tdata[47:24] == '0) begin
                                o_m_tvalid <= 1'b1;
                                o_m_tuser <= ST_OK;
                                o_m_tdata <= '0;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                    end
                    S_WALK: begin
                        r_start <= d_start;
                        r_size <= d_size;
                        r_link <= d_link;
                        if (alloc_hit) begin
                            if (split_ok) begin
                                r_state <= S_SPARE;
                            end else begin
                                o_m_tvalid <= 1'b1;
                                o_m_tuser <= ST_OK;
                                o_m_tdata <= d_start + HDR;
                                r_state <= S_IDLE;
                            end
                        end else if (free_hit) begin
                            if (at_end) begin
                                o_m_tvalid <= 1'b1;
                                o_m_tuser <= ST_OK;
                                o_m_tdata <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_nx <= d_link[AW-1:0];
                                r_state <= S_MERGE;
                            end
                        end else if (at_end) begin
                            o_m_tvalid <= 1'b1;
                            o_m_tuser <= (r_op == OP_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
                            o_m_tdata <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cur <= d_link[AW-1:0];
                        end
                    end
                    S_SPARE: begin
                        if (scan_done) begin
                            if (r_spare_ok) begin
                                r_state <= S_SPLIT2;
                            end else begin
                                o_m_tvalid <= 1'b1;
                                o_m_tuser <= ST_OK;
                                o_m_tdata <= grant;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                    S_SPLIT2: begin
                        o_m_tvalid <= 1'b1;
                        o_m_tuser <= ST_OK;
                        o_m_tdata <= grant;
                        r_state <= S_IDLE;
                    end
                    S_MERGE: begin
                        o_m_tvalid <= 1'b1;
                        o_m_tuser <= ST_OK;
                        o_m_tdata <= '0;
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_clr <= '0;
                        r_state <= S_INIT;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/ffa_chk.sv =====
// Port-level assertion checker for the first-fit arena allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ffa_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);
    import ffa_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Second request taken before the first was answered.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tdata == 24'd0)
        else $error("Failed request carries an offset.");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == ST_OK || o_m_tuser == ST_NO_FIT || o_m_tuser == ST_UNKNOWN)
        else $error("Undefined status code.");
endmodule

bind first_fit_arena_allocator_core ffa_chk u_ffa_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
`default_nettype wire
